/* hw/rtl/sckb_pkg.sv */
// Shared types and constants for the scan code to character key buffer.
// No dependencies; imported by every module of the block.
`default_nettype none

package sckb_pkg;

    // Sizes of the key queue and of the layout tables.
    localparam int FIFO_DEPTH  = 16;
    localparam int TABLE_DEPTH = 128;
    localparam int NUM_TABLES  = 3;
    localparam int MEM_DEPTH   = NUM_TABLES * TABLE_DEPTH;

    // Field widths.
    localparam int CHAR_W  = 8;
    localparam int CODE_W  = 7;
    localparam int SEL_W   = 2;
    localparam int REQ_W   = 2;
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int MEM_AW  = SEL_W + CODE_W;

    // Bit 7 of a scan code marks a key release; the low seven bits are the key code.
    localparam int RELEASE_BIT = CHAR_W - 1;

    // Configuration register indexes and their reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SHIFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPS_LOCK   = 2'd2;
    localparam logic [CODE_W-1:0] LEFT_SHIFT_RST  = 7'd42;
    localparam logic [CODE_W-1:0] RIGHT_SHIFT_RST = 7'd54;
    localparam logic [CODE_W-1:0] CAPS_LOCK_RST   = 7'd58;

    // Request kinds carried with each input word.
    typedef enum logic [REQ_W-1:0] {
        REQ_SCAN = 2'd0,
        REQ_READ = 2'd1,
        REQ_LOAD = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    // Layout table selectors; the last one has no table behind it.
    localparam logic [SEL_W-1:0] TBL_PLAIN  = 2'd0;
    localparam logic [SEL_W-1:0] TBL_SHIFT  = 2'd1;
    localparam logic [SEL_W-1:0] TBL_CAPS   = 2'd2;
    localparam logic [SEL_W-1:0] TBL_UNUSED = 2'd3;

    // Command handed to the queue chain for one item.
    typedef struct packed {
        logic              flush;
        logic              push;
        logic              pop;
        logic [CHAR_W-1:0] data;
    } fifo_cmd_t;

    // Status returned by the queue chain.
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  count_next;
        logic [CHAR_W-1:0] head;
    } fifo_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/scancode_to_ascii_key_buffer_core.sv */
// Top level of the scan code to character key buffer.
// Depends on sckb_pkg and sckb_chain (which uses sckb_cell).
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata/s_tuser) takes one request
//   word: a scan code, a read of the oldest key, or a load of one layout
//   table entry, selected by the request kind in s_tuser. Each word gives
//   exactly one result word on the master channel (m_tvalid/m_tready/
//   m_tdata/m_tuser) with the popped key, the queue fill and the flags.
//   The three key codes (left shift, right shift, caps lock) are set through
//   the write port cfg_we/cfg_index/cfg_wdata; the user must write them only
//   while the block is idle, which the block itself does not enforce.
//   One word is in work at a time, so no new word is taken before the last
//   is worked off: its layout table entry is read on acceptance (registered
//   read port), then the key queue, the flags and the result are updated.
//   The layout tables must be loaded before scan codes are sent; an entry
//   never loaded gives an undefined character.
//   Reset clears the queue fill, both flags and the output valid, and loads
//   the default key codes. When the receiver stalls, the result is held in
//   the output register and s_tready drops once the next word has been read
//   from the table, until the waiting result is taken.
`default_nettype none

module scancode_to_ascii_key_buffer_core
    import sckb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port.
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CODE_W-1:0]    cfg_wdata,
    // Request channel.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata: scan_code[7:0], table_index[14:8], table_value[22:15], zero[23].
    input  wire logic [23:0]          s_tdata,
    // s_tuser: req_type[1:0], table_select[3:2].
    input  wire logic [3:0]           s_tuser,
    // Result channel.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata: key_char[7:0], buffer_count[12:8], shift_active[13],
    //          caps_active[14], buffer_flushed[15].
    output logic [15:0]               m_tdata,
    // m_tuser: key_valid[0].
    output logic                      m_tuser
);

    // Configuration registers.
    logic [CODE_W-1:0] left_shift_reg;
    logic [CODE_W-1:0] right_shift_reg;
    logic [CODE_W-1:0] caps_code_reg;

    // Control state.
    logic busy_reg;
    logic shift_reg;
    logic shift_next;
    logic caps_reg;
    logic caps_next;
    logic out_valid_reg;

    // Captured request word.
    req_t              item_req_reg;
    logic [CHAR_W-1:0] item_scan_reg;
    logic [SEL_W-1:0]  item_sel_reg;
    logic [CODE_W-1:0] item_idx_reg;
    logic [CHAR_W-1:0] item_val_reg;
    logic [CHAR_W-1:0] rdata_reg;

    // Result register.
    logic              out_key_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_shift_reg;
    logic              out_caps_reg;
    logic              out_flushed_reg;

    // Layout table memory.
    logic [CHAR_W-1:0] layout_mem [MEM_DEPTH];
    logic [MEM_AW-1:0] rd_addr;
    logic [SEL_W-1:0]  rd_sel;
    logic              mem_we;

    logic       s_fire;
    logic       exec;
    fifo_cmd_t  fcmd;
    fifo_stat_t fstat;

    logic [CODE_W-1:0] code;
    logic              is_release;
    logic              is_shift;
    logic              is_full;
    logic              key_valid;
    logic [CHAR_W-1:0] key_char;

    assign s_tready = !busy_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign exec     = busy_reg && (!out_valid_reg || m_tready);

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_shift_reg  <= LEFT_SHIFT_RST;
            right_shift_reg <= RIGHT_SHIFT_RST;
            caps_code_reg   <= CAPS_LOCK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEFT_SHIFT:  left_shift_reg  <= cfg_wdata;
                CFG_RIGHT_SHIFT: right_shift_reg <= cfg_wdata;
                CFG_CAPS_LOCK:   caps_code_reg   <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Capture the request word on acceptance.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_req_reg  <= req_t'(s_tuser[1:0]);
            item_sel_reg  <= s_tuser[3:2];
            item_scan_reg <= s_tdata[7:0];
            item_idx_reg  <= s_tdata[14:8];
            item_val_reg  <= s_tdata[22:15];
        end
    end

    // The table to look in follows the flags as they stand at acceptance;
    // they cannot change before this word is worked off.
    assign rd_sel  = shift_reg ? TBL_SHIFT : (caps_reg ? TBL_CAPS : TBL_PLAIN);
    assign rd_addr = {rd_sel, s_tdata[CODE_W-1:0]};
    assign mem_we  = exec && (item_req_reg == REQ_LOAD) && (item_sel_reg != TBL_UNUSED);

    // Layout table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            layout_mem[{item_sel_reg, item_idx_reg}] <= item_val_reg;
        end
        if (s_fire)
        begin
            rdata_reg <= layout_mem[rd_addr];
        end
    end

    // Decode of the captured word, used when the word is worked off.
    assign code       = item_scan_reg[CODE_W-1:0];
    assign is_release = item_scan_reg[RELEASE_BIT];
    assign is_shift   = (code == left_shift_reg) || (code == right_shift_reg);
    assign is_full    = (fstat.count == CNT_W'(FIFO_DEPTH));

    always_comb
    begin
        fcmd       = '0;
        fcmd.data  = rdata_reg;
        shift_next = shift_reg;
        caps_next  = caps_reg;
        key_valid  = 1'b0;
        key_char   = '0;
        if (exec)
        begin
            unique case (item_req_reg)
                REQ_SCAN:
                begin
                    // A full queue is emptied before any scan code is handled.
                    fcmd.flush = is_full;
                    if (is_release)
                    begin
                        if (is_shift)
                        begin
                            shift_next = 1'b0;
                        end
                    end
                    else if (is_shift)
                    begin
                        shift_next = 1'b1;
                    end
                    else if (code == caps_code_reg)
                    begin
                        caps_next = !caps_reg;
                    end
                    else
                    begin
                        fcmd.push = 1'b1;
                    end
                end
                REQ_READ:
                begin
                    if (fstat.count != '0)
                    begin
                        fcmd.pop  = 1'b1;
                        key_valid = 1'b1;
                        key_char  = fstat.head;
                    end
                end
                default: ;
            endcase
        end
    end

    sckb_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (fcmd),
        .stat  (fstat)
    );

    // Busy, flags and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            shift_reg     <= 1'b0;
            caps_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
            if (s_fire)
            begin
                busy_reg <= 1'b1;
            end
            else if (exec)
            begin
                busy_reg <= 1'b0;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_key_valid_reg <= key_valid;
            out_char_reg      <= key_char;
            out_count_reg     <= fstat.count_next;
            out_shift_reg     <= shift_next;
            out_caps_reg      <= caps_next;
            out_flushed_reg   <= fcmd.flush;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_key_valid_reg;
    assign m_tdata  = {out_flushed_reg, out_caps_reg, out_shift_reg,
                       out_count_reg, out_char_reg};

    // A new result only ever follows a word in work.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg))
        else $error("result appeared without a word in work");

    // An accepted word is always in work on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> busy_reg)
        else $error("accepted word was not taken into work");

    // The queue never reports more bytes than it holds.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg <= CNT_W'(FIFO_DEPTH)))
        else $error("buffer count beyond queue depth");

    // A popped key and a flush never come from the same word.
    a_pop_not_flush: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_key_valid_reg && out_flushed_reg))
        else $error("key popped by a flushing word");

    // A pop only happens on a queue that holds bytes.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        fcmd.pop |-> (fstat.count != '0) && !fcmd.push)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

/* hw/rtl/sckb_cell.sv */
// One storage cell of the key queue chain: holds a byte and passes it on.
// Depends on sckb_pkg for the character width.
`default_nettype none

module sckb_cell
    import sckb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              shift_en,
    input  wire logic              load_en,
    input  wire logic [CHAR_W-1:0] load_data,
    input  wire logic [CHAR_W-1:0] next_data,
    output logic      [CHAR_W-1:0] data
);

    logic [CHAR_W-1:0] data_reg;
    logic [CHAR_W-1:0] data_next;

    // A load writes a new byte; a shift takes the byte of the cell behind.
    always_comb
    begin
        data_next = data_reg;
        if (load_en)
        begin
            data_next = load_data;
        end
        else if (shift_en)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/sckb_chain.sv */
// Key queue built as a row of cells; the oldest byte sits in cell 0.
// Depends on sckb_pkg and sckb_cell.
`default_nettype none

module sckb_chain
    import sckb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire fifo_cmd_t  cmd,
    output fifo_stat_t      stat
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  base_count;
    logic [CHAR_W-1:0] cell_data [FIFO_DEPTH];

    // A flush empties the queue before any push of the same item.
    always_comb
    begin
        base_count = cmd.flush ? '0 : count_reg;
        count_next = base_count;
        if (cmd.push)
        begin
            count_next = base_count + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = base_count - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Row of cells: a pop moves every byte one place toward the head,
    // a push writes the cell just past the last occupied one.
    for (genvar i = 0; i < FIFO_DEPTH; i++)
    begin : g_cell
        logic [CHAR_W-1:0] behind;

        if (i == FIFO_DEPTH - 1)
        begin : g_tail
            assign behind = cell_data[i];
        end
        else
        begin : g_body
            assign behind = cell_data[i+1];
        end

        sckb_cell u_cell (
            .clk       (clk),
            .shift_en  (cmd.pop),
            .load_en   (cmd.push && (base_count == CNT_W'(i))),
            .load_data (cmd.data),
            .next_data (behind),
            .data      (cell_data[i])
        );
    end

    assign stat.count      = count_reg;
    assign stat.count_next = count_next;
    assign stat.head       = cell_data[0];

endmodule

`default_nettype wire
